// File: rtl/tpsa_pkg.sv
// shared widths, codes and types of the two-pool slot allocator
package tpsa_pkg;

	localparam int SLOT_W = 10;
	localparam int POOL_W = 2;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [POOL_W-1:0] POOL_FIRST  = 2'd0;
	localparam logic [POOL_W-1:0] POOL_SECOND = 2'd1;

	typedef enum logic {
		S_IDLE,
		S_READ
	} tpsa_state_t;

endpackage

// File: rtl/tpsa_req_if.sv
// request channel: allocate or release of a slot
interface tpsa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [tpsa_pkg::POOL_W-1:0]   pool;
	logic [tpsa_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, kind, pool, slot, input ready);
	modport sink   (input valid, kind, pool, slot, output ready);
endinterface

// File: rtl/tpsa_rsp_if.sv
// response channel: outcome of one request
interface tpsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [tpsa_pkg::SLOT_W-1:0]   granted_slot;
	logic                          pushed;
	logic                          stack_overflow;

	modport source (output valid, ok, granted_slot, pushed, stack_overflow, input ready);
	modport sink   (input valid, ok, granted_slot, pushed, stack_overflow, output ready);
endinterface

// File: rtl/tpsa_stack_ram.sv
// free stack storage: one write port, one registered read port
module tpsa_stack_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/two_pool_slot_allocator_core.sv
// two-pool slot allocator: bump pointers plus a lifo free stack per pool
//
//  port  | role   | payload
//  ------+--------+-------------------------------------------------
//  req   | sink   | kind, pool, slot
//  rsp   | source | ok, granted_slot, pushed, stack_overflow
//
// one item per cycle while the output is free; an allocate served from
// a free stack waits in S_READ for the registered stack ram read
// reset clears the started flag, bump pointers and free counts; the stack
// rams hold no reset value and are only read below the free count
// a result waits in the output register; req stays ready while it is taken
// in the same cycle, and stalls when it is held or while in S_READ
module two_pool_slot_allocator_core #(
	parameter int FIRST_SLOTS  = 256,
	parameter int SECOND_SLOTS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	tpsa_req_if.sink  req,
	tpsa_rsp_if.source rsp
);

	localparam int SLOT_W = tpsa_pkg::SLOT_W;

	// counter, address and entry widths per pool
	localparam int FW   = $clog2(FIRST_SLOTS + 1);
	localparam int FAW  = $clog2(FIRST_SLOTS);
	localparam int FEW  = (FAW < SLOT_W) ? FAW : SLOT_W;
	localparam int FCW  = (FW > SLOT_W) ? FW : SLOT_W;
	localparam int SW   = $clog2(SECOND_SLOTS + 1);
	localparam int SAW  = $clog2(SECOND_SLOTS);
	localparam int SEW  = (SAW < SLOT_W) ? SAW : SLOT_W;
	localparam int SCW  = (SW > SLOT_W) ? SW : SLOT_W;

	tpsa_pkg::tpsa_state_t state_q, state_d;

	logic          started_q, started_d;
	logic [FW-1:0] f_bump_q, f_bump_d, f_count_q, f_count_d;
	logic [SW-1:0] s_bump_q, s_bump_d, s_count_q, s_count_d;
	logic          pop_second_q, pop_second_d;

	logic              rsp_valid_q;
	logic              ok_q, ok_d;
	logic [SLOT_W-1:0] grant_q, grant_d;
	logic              pushed_q, pushed_d;
	logic              ovf_q, ovf_d;
	logic              load;

	logic out_free, req_ready, accept;

	logic [FCW-1:0] f_bump_ext, f_slot_ext;
	logic [SCW-1:0] s_bump_ext, s_slot_ext;

	logic           f_we, f_re, s_we, s_re;
	logic [FAW-1:0] f_wr_addr, f_rd_addr;
	logic [SAW-1:0] s_wr_addr, s_rd_addr;
	logic [FEW-1:0] f_wr_data, f_rd_data;
	logic [SEW-1:0] s_wr_data, s_rd_data;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req_ready = (state_q == tpsa_pkg::S_IDLE) && out_free;
	assign accept    = req.valid && req_ready;
	assign req.ready = req_ready;

	assign f_bump_ext = FCW'(f_bump_q);
	assign f_slot_ext = FCW'(req.slot);
	assign s_bump_ext = SCW'(s_bump_q);
	assign s_slot_ext = SCW'(req.slot);

	// pop reads the entry below the count, push writes at the count
	assign f_rd_addr = FAW'(f_count_q - 1'b1);
	assign f_wr_addr = FAW'(f_count_q);
	assign f_wr_data = FEW'(req.slot);
	assign s_rd_addr = SAW'(s_count_q - 1'b1);
	assign s_wr_addr = SAW'(s_count_q);
	assign s_wr_data = SEW'(req.slot);

	tpsa_stack_ram #(
		.DEPTH (FIRST_SLOTS),
		.WIDTH (FEW)
	) u_first_stack (
		.clk     (clk),
		.wr_en   (f_we),
		.wr_addr (f_wr_addr),
		.wr_data (f_wr_data),
		.rd_en   (f_re),
		.rd_addr (f_rd_addr),
		.rd_data (f_rd_data)
	);

	tpsa_stack_ram #(
		.DEPTH (SECOND_SLOTS),
		.WIDTH (SEW)
	) u_second_stack (
		.clk     (clk),
		.wr_en   (s_we),
		.wr_addr (s_wr_addr),
		.wr_data (s_wr_data),
		.rd_en   (s_re),
		.rd_addr (s_rd_addr),
		.rd_data (s_rd_data)
	);

	always_comb begin
		state_d      = state_q;
		started_d    = started_q;
		f_bump_d     = f_bump_q;
		f_count_d    = f_count_q;
		s_bump_d     = s_bump_q;
		s_count_d    = s_count_q;
		pop_second_d = pop_second_q;
		load         = 1'b0;
		ok_d         = 1'b0;
		grant_d      = '0;
		pushed_d     = 1'b0;
		ovf_d        = 1'b0;
		f_we         = 1'b0;
		f_re         = 1'b0;
		s_we         = 1'b0;
		s_re         = 1'b0;
		case (state_q)
			tpsa_pkg::S_IDLE: begin
				if (accept) begin
					if (req.kind == tpsa_pkg::KIND_ALLOC) begin
						started_d = 1'b1;
						if (req.pool == tpsa_pkg::POOL_FIRST) begin
							if (f_count_q != '0) begin
								f_count_d    = f_count_q - 1'b1;
								f_re         = 1'b1;
								pop_second_d = 1'b0;
								state_d      = tpsa_pkg::S_READ;
							end else if (f_bump_q != FW'(FIRST_SLOTS)) begin
								load     = 1'b1;
								ok_d     = 1'b1;
								grant_d  = f_bump_ext[SLOT_W-1:0];
								f_bump_d = f_bump_q + 1'b1;
							end else begin
								load = 1'b1;
							end
						end else if (req.pool == tpsa_pkg::POOL_SECOND) begin
							if (s_count_q != '0) begin
								s_count_d    = s_count_q - 1'b1;
								s_re         = 1'b1;
								pop_second_d = 1'b1;
								state_d      = tpsa_pkg::S_READ;
							end else if (s_bump_q != SW'(SECOND_SLOTS)) begin
								load     = 1'b1;
								ok_d     = 1'b1;
								grant_d  = s_bump_ext[SLOT_W-1:0];
								s_bump_d = s_bump_q + 1'b1;
							end else begin
								load = 1'b1;
							end
						end else begin
							load = 1'b1;
						end
					end else begin
						load = 1'b1;
						if (started_q && req.pool == tpsa_pkg::POOL_FIRST) begin
							ok_d = 1'b1;
							// slots at or above the bump pointer were never handed out
							if (f_slot_ext < f_bump_ext) begin
								if (f_count_q == FW'(FIRST_SLOTS)) begin
									ovf_d = 1'b1;
								end else begin
									f_we      = 1'b1;
									f_count_d = f_count_q + 1'b1;
									pushed_d  = 1'b1;
								end
							end
						end else if (started_q && req.pool == tpsa_pkg::POOL_SECOND) begin
							ok_d = 1'b1;
							if (s_slot_ext < s_bump_ext) begin
								if (s_count_q == SW'(SECOND_SLOTS)) begin
									ovf_d = 1'b1;
								end else begin
									s_we      = 1'b1;
									s_count_d = s_count_q + 1'b1;
									pushed_d  = 1'b1;
								end
							end
						end
					end
				end
			end
			tpsa_pkg::S_READ: begin
				// stack entry is out of the ram now
				load    = 1'b1;
				ok_d    = 1'b1;
				grant_d = pop_second_q ? SLOT_W'(s_rd_data) : SLOT_W'(f_rd_data);
				state_d = tpsa_pkg::S_IDLE;
			end
			default: begin
				state_d = tpsa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tpsa_pkg::S_IDLE;
			started_q    <= 1'b0;
			f_bump_q     <= '0;
			f_count_q    <= '0;
			s_bump_q     <= '0;
			s_count_q    <= '0;
			pop_second_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			started_q    <= started_d;
			f_bump_q     <= f_bump_d;
			f_count_q    <= f_count_d;
			s_bump_q     <= s_bump_d;
			s_count_q    <= s_count_d;
			pop_second_q <= pop_second_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q     <= ok_d;
			grant_q  <= grant_d;
			pushed_q <= pushed_d;
			ovf_q    <= ovf_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = ok_q;
	assign rsp.granted_slot   = grant_q;
	assign rsp.pushed         = pushed_q;
	assign rsp.stack_overflow = ovf_q;

	a_first_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		f_count_q <= FW'(FIRST_SLOTS))
		else $error("first free count above pool size");

	a_second_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		s_count_q <= SW'(SECOND_SLOTS))
		else $error("second free count above pool size");

	a_read_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tpsa_pkg::S_READ |-> $past(accept))
		else $error("stack read without an accepted item");

	a_pushed_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && pushed_q |-> ok_q && !ovf_q && grant_q == '0)
		else $error("pushed result with inconsistent flags");

	a_overflow_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && ovf_q |-> ok_q && !pushed_q)
		else $error("overflow result without ok");

endmodule
